[hdl/epru_pkg.sv]
package epru_pkg;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STEP   = 2'd1,
		CMD_SAMPLE = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	localparam int THR_W = 17;
	localparam int RND_W = 16;
	localparam int SITE_W = 8;
	localparam int OUT_COUNT_W = 32;

	localparam logic REG_FREE_THR    = 1'b0;
	localparam logic REG_BLOCKED_THR = 1'b1;

	localparam logic [THR_W-1:0] FREE_THR_RST    = 17'd32768;
	localparam logic [THR_W-1:0] BLOCKED_THR_RST = 17'd0;

	typedef struct packed {
		cmd_t              cmd;
		logic [SITE_W-1:0] site;
		logic              occupied;
		logic [RND_W-1:0]  random;
	} item_t;

	typedef struct packed {
		logic                   moved;
		logic [SITE_W-1:0]      stepped_site;
		logic [OUT_COUNT_W-1:0] count;
	} result_t;

	// broadcast controls shared by every cell
	typedef struct packed {
		logic load_en;
		logic load_val;
		logic step_en;
		logic win;
		logic sample_en;
	} cell_ctl_t;

endpackage

[hdl/epru_cell.sv]
module epru_cell #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  epru_pkg::cell_ctl_t    ctl,
	input  logic                   load_hit,
	input  logic                   step_hit,
	input  logic                   lower_occ,
	input  logic                   upper_hop,
	output logic                   occ,
	output logic                   hop,
	output logic [COUNT_WIDTH-1:0] count
);
	import epru_pkg::*;

	logic                   occ_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	// hand the particle to the lower neighbor when it is free and the draw wins
	assign hop   = ctl.step_en & step_hit & occ_q & ~lower_occ & ctl.win;
	assign occ   = occ_q;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (ctl.load_en && load_hit) begin
				occ_q <= ctl.load_val;
			end else if (hop) begin
				occ_q <= 1'b0;
			end else if (upper_hop) begin
				occ_q <= 1'b1;
			end
			// saturate at all ones
			if (ctl.sample_en && occ_q && !(&cnt_q)) begin
				cnt_q <= cnt_q + COUNT_WIDTH'(1);
			end
		end
	end

endmodule

[hdl/exclusion_process_ring_update.sv]
// Exclusion-process ring: a ring of SITES cells, each holding one occupancy
// bit and a saturating occupancy counter, with a particle passed from a cell
// to its lower neighbor on a winning step. Issue a command by raising start
// while busy is low; the item is registered, the cells act on it in the
// following cycle, and the result is shown on result for exactly one cycle
// with done high, from the result register behind the cells. busy is high
// for the one cycle in which the cells act, so a new item is not taken
// while the registered command stage still holds the last one. The receiver
// cannot stall: sample done when it shows. Every command returns one
// result: moved and stepped_site are meaningful for step, count for read, and
// the unused fields are zero. Load also rewinds the sweep pointer to site 0
// and clears the previous-site flag. Write thresholds (UQ1.16, 65536 means
// always hop) through cfg_we/cfg_index/cfg_data only while the block is idle.
// Reset clears every cell at once; no clearing pass is needed.
module exclusion_process_ring_update #(
	parameter int SITES       = 256,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  epru_pkg::item_t                       item,
	output logic                                  done,
	output epru_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [epru_pkg::THR_W-1:0]            cfg_data
);
	import epru_pkg::*;

	localparam int PW = $clog2(SITES);
	// wide enough to hold SITES itself and the raw site field
	localparam int IW = (PW + 1 > SITE_W + 1) ? PW + 1 : SITE_W + 1;

	// threshold registers
	logic [THR_W-1:0] free_thr_q;
	logic [THR_W-1:0] blocked_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_thr_q    <= FREE_THR_RST;
			blocked_thr_q <= BLOCKED_THR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FREE_THR:    free_thr_q    <= cfg_data;
				REG_BLOCKED_THR: blocked_thr_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// command stage: hold the accepted item for the cycle the cells act
	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign accept = start & ~valid_s1;
	assign busy   = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// sweep state
	logic [PW-1:0] ptr_q;
	logic          prev_full_q;

	// decode the command
	logic is_load, is_step, is_sample, is_read;
	always_comb begin
		is_load   = 1'b0;
		is_step   = 1'b0;
		is_sample = 1'b0;
		is_read   = 1'b0;
		unique case (item_s1.cmd)
			CMD_LOAD:   is_load   = valid_s1;
			CMD_STEP:   is_step   = valid_s1;
			CMD_SAMPLE: is_sample = valid_s1;
			CMD_READ:   is_read   = valid_s1;
			default:    ;
		endcase
	end

	// site index and range check for load and read
	logic [IW-1:0] site_ext;
	logic          site_ok;
	logic [PW-1:0] site_idx;

	assign site_ext = IW'(item_s1.site);
	assign site_ok  = site_ext < IW'(SITES);
	assign site_idx = site_ext[PW-1:0];

	// hop draw against the threshold picked by the previous site
	logic [THR_W-1:0] thr;
	logic             win;

	assign thr = prev_full_q ? blocked_thr_q : free_thr_q;
	assign win = {1'b0, item_s1.random} < thr;

	cell_ctl_t ctl;
	assign ctl = '{
		load_en:   is_load & site_ok,
		load_val:  item_s1.occupied,
		step_en:   is_step,
		win:       win,
		sample_en: is_sample
	};

	// row of cells, closed into a ring
	logic [SITES-1:0]       occ_vec;
	logic [SITES-1:0]       hop_vec;
	logic [COUNT_WIDTH-1:0] cnt_arr [SITES];

	for (genvar g = 0; g < SITES; g++) begin : g_cell
		epru_cell #(
			.COUNT_WIDTH(COUNT_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_hit (site_idx == PW'(g)),
			.step_hit (ptr_q == PW'(g)),
			.lower_occ(occ_vec[(g + SITES - 1) % SITES]),
			.upper_hop(hop_vec[(g + 1) % SITES]),
			.occ      (occ_vec[g]),
			.hop      (hop_vec[g]),
			.count    (cnt_arr[g])
		);
	end

	logic cur_occ;
	assign cur_occ = occ_vec[ptr_q];

	// advance the sweep pointer on a step, wrapping after the last site; a load rewinds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			prev_full_q <= 1'b0;
		end else if (is_load) begin
			ptr_q       <= '0;
			prev_full_q <= 1'b0;
		end else if (is_step) begin
			ptr_q       <= (ptr_q == PW'(SITES - 1)) ? '0 : ptr_q + PW'(1);
			prev_full_q <= cur_occ;
		end
	end

	// read path: pick one counter, clip to the output width
	logic [COUNT_WIDTH-1:0] rd_cnt;
	logic [OUT_COUNT_W-1:0] rd_clip;

	assign rd_cnt = cnt_arr[site_idx];

	if (COUNT_WIDTH > OUT_COUNT_W) begin : g_clip
		assign rd_clip = (|rd_cnt[COUNT_WIDTH-1:OUT_COUNT_W]) ? '1 : rd_cnt[OUT_COUNT_W-1:0];
	end else begin : g_ext
		assign rd_clip = OUT_COUNT_W'(rd_cnt);
	end

	// result register: one-cycle strobe
	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.moved        <= is_step & (|hop_vec);
			result_q.stepped_site <= is_step ? SITE_W'(ptr_q) : '0;
			result_q.count        <= (is_read && site_ok) ? rd_clip : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// checks
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("result strobe missing after cell cycle");

	a_moved_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_step |=> !result.moved)
		else $error("moved set for a command other than step");

	a_step_keeps_particles: assert property (@(posedge clk) disable iff (!arst_n)
		is_step |=> $countones(occ_vec) == $past($countones(occ_vec)))
		else $error("step changed the number of particles");

	a_single_hop: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hop_vec))
		else $error("more than one cell hopped");

endmodule

[verif/testbench.sv]
module testbench;
	import epru_pkg::*;

	localparam int RING_SIZE = 1 << SITE_W;

	// Mirror of the ring: occupancy, saturating tallies, sweep pointer and
	// the previous-site flag, plus the results still owed by the block.
	class ring_shadow;
		bit [RING_SIZE-1:0]   occupied_map;
		bit [OUT_COUNT_W-1:0] tally [RING_SIZE];
		bit [SITE_W-1:0]      sweep;
		bit                   last_full;
		bit [THR_W-1:0]       free_thr;
		bit [THR_W-1:0]       blocked_thr;
		result_t              awaited [$];
		int                   mismatches;

		function new();
			occupied_map = '0;
			foreach (tally[i]) tally[i] = '0;
			sweep = '0;
			last_full = 1'b0;
			free_thr = FREE_THR_RST;
			blocked_thr = BLOCKED_THR_RST;
			mismatches = 0;
		endfunction

		function void set_threshold(logic idx, bit [THR_W-1:0] val);
			if (idx == REG_FREE_THR) begin
				free_thr = val;
			end else begin
				blocked_thr = val;
			end
		endfunction

		function void apply_item(item_t it);
			result_t         r;
			bit [SITE_W-1:0] cur;
			bit [SITE_W-1:0] below;
			bit [THR_W-1:0]  thr;
			r = '0;
			case (it.cmd)
				CMD_LOAD: begin
					occupied_map[it.site] = it.occupied;
					sweep = '0;
					last_full = 1'b0;
				end
				CMD_STEP: begin
					cur = sweep;
					below = cur - 1'b1;
					if (occupied_map[cur]) begin
						thr = last_full ? blocked_thr : free_thr;
						if (!occupied_map[below] && {1'b0, it.random} < thr) begin
							occupied_map[cur] = 1'b0;
							occupied_map[below] = 1'b1;
							r.moved = 1'b1;
						end
						last_full = 1'b1;
					end else begin
						last_full = 1'b0;
					end
					r.stepped_site = cur;
					sweep = cur + 1'b1;
				end
				CMD_SAMPLE: begin
					for (int i = 0; i < RING_SIZE; i++)
						if (occupied_map[i] && tally[i] != '1)
							tally[i]++;
				end
				default: begin
					r.count = tally[it.site];
				end
			endcase
			awaited.push_back(r);
		endfunction

		function void compare_result(result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: moved=%0b site=%0d count=%0d",
						got.moved, got.stepped_site, got.count);
				return;
			end
			want = awaited.pop_front();
			if (got.moved !== want.moved || got.stepped_site !== want.stepped_site ||
					got.count !== want.count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected moved=%0b site=%0d count=%0d,",
						want.moved, want.stepped_site, want.count,
						" got moved=%0b site=%0d count=%0d",
						got.moved, got.stepped_site, got.count);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	item_t            item;
	logic             done;
	result_t          result;
	logic             cfg_we;
	logic             cfg_index;
	logic [THR_W-1:0] cfg_data;

	ring_shadow shadow = new();
	int         burst_left;

	exclusion_process_ring_update dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// The receiver cannot stall: check every result in the cycle it shows.
	always @(posedge clk) begin
		if (arst_n && done)
			shadow.compare_result(result);
	end

	function automatic item_t make_item(cmd_t c, int s, bit o, int rnd);
		item_t it;
		it.cmd = c;
		it.site = s[SITE_W-1:0];
		it.occupied = o;
		it.random = rnd[RND_W-1:0];
		return it;
	endfunction

	// Present one item and hold it until the block takes it. Entered and left
	// at a falling edge; start stays high on exit so back-to-back items need no
	// second assignment in the same step. Between bursts, drop start for a
	// random gap so that idle cycles land on both phases of the block's cycle.
	task automatic issue(input item_t it);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(40, 120);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		shadow.apply_item(it);
		@(negedge clk);
	endtask

	// Drop start and drain every outstanding result, then idle a few cycles.
	task automatic settle();
		int waited;
		start <= 1'b0;
		burst_left = 0;
		waited = 0;
		while (shadow.awaited.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	// Write one threshold register; leaves cfg_we high for the caller to drop.
	task automatic write_threshold(input logic idx, input logic [THR_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		shadow.set_threshold(idx, val);
		@(negedge clk);
	endtask

	// One phase: set both thresholds, populate the whole ring at a random
	// density, then mostly steps with samples and reads mixed in. Loads only
	// come late, since each rewinds the sweep.
	task automatic run_phase(input logic [THR_W-1:0] free_val,
			input logic [THR_W-1:0] blocked_val);
		int density;
		int pick;
		item_t it;
		settle();
		write_threshold(REG_FREE_THR, free_val);
		write_threshold(REG_BLOCKED_THR, blocked_val);
		cfg_we <= 1'b0;
		density = $urandom_range(20, 80);
		for (int s = 0; s < RING_SIZE; s++)
			issue(make_item(CMD_LOAD, s, $urandom_range(0, 99) < density,
				$urandom_range(0, 65535)));
		for (int n = 0; n < 300; n++) begin
			it = make_item(CMD_STEP, $urandom_range(0, RING_SIZE - 1),
				1'($urandom_range(0, 1)), $urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			if (n >= 260 && pick < 15)
				it.cmd = CMD_LOAD;
			else if (pick < 78)
				it.cmd = CMD_STEP;
			else if (pick < 89)
				it.cmd = CMD_SAMPLE;
			else
				it.cmd = CMD_READ;
			issue(it);
		end
	endtask

	initial begin
		start <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FREE_THR;
		cfg_data <= '0;
		arst_n <= 1'b0;
		burst_left = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under reset thresholds (free half, blocked never).
		// Hop across the wrap from site 0 to the top site, a blocked-threshold
		// refusal right after, an empty site, threshold boundary values, and
		// reads of sampled and never-sampled counters.
		issue(make_item(CMD_READ, 0, 1'b0, 0));
		issue(make_item(CMD_LOAD, RING_SIZE - 1, 1'b0, 16'hFFFF));
		issue(make_item(CMD_LOAD, 0, 1'b1, 0));
		issue(make_item(CMD_LOAD, 1, 1'b1, 0));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h0000));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h0000));
		issue(make_item(CMD_STEP, RING_SIZE - 1, 1'b1, 16'hFFFF));
		issue(make_item(CMD_SAMPLE, RING_SIZE - 1, 1'b1, 16'hFFFF));
		issue(make_item(CMD_READ, RING_SIZE - 1, 1'b1, 16'hFFFF));
		issue(make_item(CMD_READ, 1, 1'b0, 0));
		issue(make_item(CMD_READ, 0, 1'b0, 0));
		issue(make_item(CMD_LOAD, 2, 1'b1, 0));
		issue(make_item(CMD_LOAD, 3, 1'b1, 0));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h8000));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h7FFF));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h0000));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h0000));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h8000));
		issue(make_item(CMD_LOAD, 10, 1'b1, 0));
		issue(make_item(CMD_STEP, 0, 1'b0, 16'h8000));
		issue(make_item(CMD_SAMPLE, 0, 1'b0, 0));
		issue(make_item(CMD_READ, 0, 1'b0, 0));
		issue(make_item(CMD_READ, 10, 1'b1, 16'hFFFF));

		// Threshold settings: never/always, always/above-range, off-by-one
		// from each end, then random.
		run_phase(17'd0, 17'd65536);
		run_phase(17'd65536, 17'h1FFFF);
		run_phase(17'd1, 17'd65535);
		run_phase(THR_W'($urandom_range(0, 65536)), THR_W'($urandom_range(0, 65536)));

		settle();
		repeat (8) @(posedge clk);
		if (shadow.awaited.size() != 0)
			shadow.mismatches += shadow.awaited.size();
		if (shadow.mismatches == 0) begin
			$display("exclusion_process_ring_update regression: pass");
		end else begin
			$display("exclusion_process_ring_update regression: fail");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4000000;
		$display("exclusion_process_ring_update regression: fail");
		$finish;
	end

endmodule
